@@ sv/bre_pkg.sv @@
// ----------------------------------------------------------------------------
// bre_pkg
// Shared types and constants of the box regression target encoder.
// ----------------------------------------------------------------------------
package bre_pkg;

  localparam int MAX_CLASSES        = 128;
  localparam int LOG_TABLE_BITS_DEF = 10;

  localparam int LN2_Q24    = 11629080;
  localparam int LN2_LO_W   = 12;
  localparam int LN2_HI     = LN2_Q24 >> LN2_LO_W;
  localparam int LN2_LO     = LN2_Q24 & ((1 << LN2_LO_W) - 1);

  localparam logic [7:0] CLASS_COUNT_RST   = 8'd81;
  localparam logic [7:0] CENTER_WEIGHT_RST = 8'd160;
  localparam logic [7:0] SIZE_WEIGHT_RST   = 8'd80;

  localparam logic [1:0] CFG_CLASS_COUNT   = 2'd0;
  localparam logic [1:0] CFG_CENTER_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_SIZE_WEIGHT   = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_GEOM  = 2'd1;
  localparam logic [1:0] ERR_LABEL = 2'd2;

  typedef struct packed {
    logic [19:0] prop_left;
    logic [19:0] prop_top;
    logic [19:0] prop_right;
    logic [19:0] prop_bottom;
    logic [19:0] truth_left;
    logic [19:0] truth_top;
    logic [19:0] truth_right;
    logic [19:0] truth_bottom;
    logic [6:0]  class_label;
  } req_t;

  typedef struct packed {
    logic               foreground;
    logic [6:0]         class_slot;
    logic signed [23:0] delta_x;
    logic signed [23:0] delta_y;
    logic signed [23:0] delta_w;
    logic signed [23:0] delta_h;
    logic [1:0]         error_code;
  } rsp_t;

endpackage

@@ sv/bre_ram.sv @@
// ----------------------------------------------------------------------------
// bre_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bre_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ sv/box_regression_target_encoder_core.sv @@
// ----------------------------------------------------------------------------
// box_regression_target_encoder_core
// Regression deltas of one region proposal against its ground-truth box.
// ----------------------------------------------------------------------------
// A request (proposal box, truth box, class label) is taken at a clock edge
// with start high and busy low. One result per request shows on result_o for
// a single cycle with result_valid_o high, once the request has passed all stages.
// A new request may be taken every cycle; results come back in order.
// The receiver cannot stall: results are never held.
// Registers class_count, center_weight and size_weight are written through
// the cfg port (valid/ready, ready always high); write them only while no
// request is in flight.
// After reset the log2 mantissa RAM is filled by an iterative squaring unit,
// one entry at a time: busy stays high until the last entry is written
// and then stays low.
// The pipeline holds the restoring divider for the center deltas, one
// quotient bit per stage (24 stages behind an entry register), behind an
// eight-stage front end that does widths, msb search, table lookup and the
// log multiplies, plus the output register.
// ----------------------------------------------------------------------------
module box_regression_target_encoder_core #(
  parameter int LOG_TABLE_BITS = bre_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bre_pkg::req_t req_i,
  output logic          result_valid_o,
  output bre_pkg::rsp_t result_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  localparam int LTB        = LOG_TABLE_BITS;
  localparam int DEPTH      = 1 << LTB;
  localparam int SQ_STEPS   = 20;
  localparam int DIV_BITS   = 24;

  // configuration
  logic [7:0] class_count_q, center_weight_q, size_weight_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q   <= bre_pkg::CLASS_COUNT_RST;
      center_weight_q <= bre_pkg::CENTER_WEIGHT_RST;
      size_weight_q   <= bre_pkg::SIZE_WEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bre_pkg::CFG_CLASS_COUNT:   class_count_q   <= cfg_data_i;
        bre_pkg::CFG_CENTER_WEIGHT: center_weight_q <= cfg_data_i;
        bre_pkg::CFG_SIZE_WEIGHT:   size_weight_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // log table fill
  logic           filling_q;
  logic [LTB-1:0] fill_idx_q;
  logic [4:0]     step_q;
  logic [30:0]    x_q;
  logic [19:0]    acc_q;
  logic [61:0]    sq;
  logic [31:0]    sq_sh;
  logic           fill_we;

  assign sq      = 62'(x_q) * 62'(x_q);
  assign sq_sh   = sq[61:30];
  assign fill_we = filling_q && (step_q == 5'(SQ_STEPS));
  assign busy    = filling_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filling_q  <= 1'b1;
      fill_idx_q <= '0;
      step_q     <= '0;
      x_q        <= {1'b1, {LTB{1'b0}}, {(30 - LTB){1'b0}}};
      acc_q      <= '0;
    end else if (filling_q) begin
      if (step_q == 5'(SQ_STEPS)) begin
        if (fill_idx_q == LTB'(DEPTH - 1)) begin
          filling_q <= 1'b0;
        end
        fill_idx_q <= fill_idx_q + 1'b1;
        step_q     <= '0;
        x_q        <= {1'b1, fill_idx_q + 1'b1, {(30 - LTB){1'b0}}};
        acc_q      <= '0;
      end else begin
        step_q <= step_q + 1'b1;
        if (sq_sh[31]) begin
          x_q   <= sq_sh[31:1];
          acc_q <= {acc_q[18:0], 1'b1};
        end else begin
          x_q   <= sq_sh[30:0];
          acc_q <= {acc_q[18:0], 1'b0};
        end
      end
    end
  end

  // helpers
  function automatic logic [4:0] msb_pos(input logic [20:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 21; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic [LTB-1:0] mant_idx(input logic [20:0] v, input logic [4:0] e);
    logic [20:0]       norm;
    logic [LTB+19:0]   ext;
    norm = v << (5'd20 - e);
    ext  = {norm[19:0], {LTB{1'b0}}};
    return ext[LTB+19:20];
  endfunction

  function automatic logic [23:0] sat_delta(input logic neg, input logic [25:0] q);
    logic [23:0] r;
    if (neg) begin
      r = (q > 26'd8388608) ? 24'h800000 : 24'(-q);
    end else begin
      r = (q > 26'd8388607) ? 24'h7fffff : q[23:0];
    end
    return r;
  endfunction

  // stage types
  typedef struct packed {
    logic        fg;
    logic [6:0]  slot;
    logic [1:0]  err;
    logic [20:0] pw, ph, tw, th;
    logic        sx, sy;
    logic [21:0] mx, my;
  } stb_t;

  typedef struct packed {
    logic        fg;
    logic [6:0]  slot;
    logic [1:0]  err;
    logic [20:0] pw, ph, tw, th;
    logic [4:0]  epw, eph, etw, eth;
    logic        sx, sy;
    logic [29:0] px, py;
  } stc_t;

  typedef struct packed {
    logic        fg;
    logic [6:0]  slot;
    logic [1:0]  err;
    logic [4:0]  epw, eph, etw, eth;
    logic        sx, sy;
    logic [42:0] nx, ny;
    logic [21:0] divx, divy;
  } std_t;

  typedef struct packed {
    logic        fg;
    logic [6:0]  slot;
    logic [1:0]  err;
    logic        sx, sy, sw, sh;
    logic [24:0] lw, lh;
    logic [42:0] nx, ny;
    logic [21:0] divx, divy;
  } ste_t;

  typedef struct packed {
    logic        fg;
    logic [6:0]  slot;
    logic [1:0]  err;
    logic        sx, sy, sw, sh;
    logic [32:0] mw, mh;
    logic [42:0] nx, ny;
    logic [21:0] divx, divy;
  } stf_t;

  typedef struct packed {
    logic        fg;
    logic [6:0]  slot;
    logic [1:0]  err;
    logic        sx, sy, sw, sh;
    logic [44:0] hw, lw, hh, lh;
    logic [42:0] nx, ny;
    logic [21:0] divx, divy;
  } stg_t;

  typedef struct packed {
    logic        fg;
    logic [6:0]  slot;
    logic [1:0]  err;
    logic        sx, sy;
    logic [23:0] dw, dh;
    logic [45:0] rx, ry;
    logic [21:0] divx, divy;
    logic [23:0] qx, qy;
    logic        ox, oy;
  } div_t;

  // stage A: request register
  logic          a_vld_q;
  bre_pkg::req_t a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else         a_vld_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) a_q <= req_i;
  end

  // stage B: widths, offsets, checks
  logic [21:0] pw_b, ph_b, tw_b, th_b;
  logic [22:0] dx_b, dy_b;
  logic        lbl_bad_b, geo_bad_b;
  stb_t        b_d, b_q;
  logic        b_vld_q;

  assign pw_b = {2'b0, a_q.prop_right}   - {2'b0, a_q.prop_left}  + 22'd16;
  assign ph_b = {2'b0, a_q.prop_bottom}  - {2'b0, a_q.prop_top}   + 22'd16;
  assign tw_b = {2'b0, a_q.truth_right}  - {2'b0, a_q.truth_left} + 22'd16;
  assign th_b = {2'b0, a_q.truth_bottom} - {2'b0, a_q.truth_top}  + 22'd16;
  assign dx_b = {3'b0, a_q.truth_left} + {3'b0, a_q.truth_right}
              - {3'b0, a_q.prop_left}  - {3'b0, a_q.prop_right};
  assign dy_b = {3'b0, a_q.truth_top} + {3'b0, a_q.truth_bottom}
              - {3'b0, a_q.prop_top}  - {3'b0, a_q.prop_bottom};

  assign lbl_bad_b = ({1'b0, a_q.class_label} >= class_count_q)
                  || (32'(a_q.class_label) >= 32'(bre_pkg::MAX_CLASSES));
  assign geo_bad_b = (a_q.class_label != '0)
                  && (pw_b[21] || pw_b == '0 || ph_b[21] || ph_b == '0
                   || tw_b[21] || tw_b == '0 || th_b[21] || th_b == '0);

  always_comb begin
    b_d.slot = a_q.class_label;
    if (lbl_bad_b)      b_d.err = bre_pkg::ERR_LABEL;
    else if (geo_bad_b) b_d.err = bre_pkg::ERR_GEOM;
    else                b_d.err = bre_pkg::ERR_OK;
    b_d.fg = !lbl_bad_b && !geo_bad_b && (a_q.class_label != '0);
    b_d.pw = pw_b[20:0];
    b_d.ph = ph_b[20:0];
    b_d.tw = tw_b[20:0];
    b_d.th = th_b[20:0];
    b_d.sx = dx_b[22];
    b_d.sy = dy_b[22];
    b_d.mx = dx_b[22] ? 22'(-dx_b) : dx_b[21:0];
    b_d.my = dy_b[22] ? 22'(-dy_b) : dy_b[21:0];
  end

  // stage C: msb search, center products
  stc_t c_d, c_q;
  logic c_vld_q;

  always_comb begin
    c_d.fg   = b_q.fg;
    c_d.slot = b_q.slot;
    c_d.err  = b_q.err;
    c_d.pw   = b_q.pw;
    c_d.ph   = b_q.ph;
    c_d.tw   = b_q.tw;
    c_d.th   = b_q.th;
    c_d.epw  = msb_pos(b_q.pw);
    c_d.eph  = msb_pos(b_q.ph);
    c_d.etw  = msb_pos(b_q.tw);
    c_d.eth  = msb_pos(b_q.th);
    c_d.sx   = b_q.sx;
    c_d.sy   = b_q.sy;
    c_d.px   = 30'(center_weight_q) * 30'(b_q.mx);
    c_d.py   = 30'(center_weight_q) * 30'(b_q.my);
  end

  // stage D: table addresses, divider operands
  std_t     d_d, d_q;
  logic     d_vld_q;
  logic [LTB-1:0] ia_w, ib_w, ia_h, ib_h;
  logic [19:0]    ta_w, tb_w, ta_h, tb_h;

  assign ia_w = mant_idx(c_q.tw, c_q.etw);
  assign ib_w = mant_idx(c_q.pw, c_q.epw);
  assign ia_h = mant_idx(c_q.th, c_q.eth);
  assign ib_h = mant_idx(c_q.ph, c_q.eph);

  bre_ram #(.WIDTH(20), .DEPTH(DEPTH)) u_ram_w (
    .clk_i     (clk_i),
    .we_i      (fill_we),
    .waddr_i   (fill_idx_q),
    .wdata_i   (acc_q),
    .raddr_a_i (ia_w),
    .rdata_a_o (ta_w),
    .raddr_b_i (ib_w),
    .rdata_b_o (tb_w)
  );

  bre_ram #(.WIDTH(20), .DEPTH(DEPTH)) u_ram_h (
    .clk_i     (clk_i),
    .we_i      (fill_we),
    .waddr_i   (fill_idx_q),
    .wdata_i   (acc_q),
    .raddr_a_i (ia_h),
    .rdata_a_o (ta_h),
    .raddr_b_i (ib_h),
    .rdata_b_o (tb_h)
  );

  always_comb begin
    d_d.fg   = c_q.fg;
    d_d.slot = c_q.slot;
    d_d.err  = c_q.err;
    d_d.epw  = c_q.epw;
    d_d.eph  = c_q.eph;
    d_d.etw  = c_q.etw;
    d_d.eth  = c_q.eth;
    d_d.sx   = c_q.sx;
    d_d.sy   = c_q.sy;
    d_d.nx   = {1'b0, c_q.px, 12'b0} + 43'(c_q.pw);
    d_d.ny   = {1'b0, c_q.py, 12'b0} + 43'(c_q.ph);
    d_d.divx = {c_q.pw, 1'b0};
    d_d.divy = {c_q.ph, 1'b0};
  end

  // stage E: log differences
  ste_t        e_d, e_q;
  logic        e_vld_q;
  logic [25:0] ldw_e, ldh_e;

  assign ldw_e = {1'b0, d_q.etw, ta_w} - {1'b0, d_q.epw, tb_w};
  assign ldh_e = {1'b0, d_q.eth, ta_h} - {1'b0, d_q.eph, tb_h};

  always_comb begin
    e_d.fg   = d_q.fg;
    e_d.slot = d_q.slot;
    e_d.err  = d_q.err;
    e_d.sx   = d_q.sx;
    e_d.sy   = d_q.sy;
    e_d.sw   = ldw_e[25];
    e_d.sh   = ldh_e[25];
    e_d.lw   = ldw_e[25] ? 25'(-ldw_e) : ldw_e[24:0];
    e_d.lh   = ldh_e[25] ? 25'(-ldh_e) : ldh_e[24:0];
    e_d.nx   = d_q.nx;
    e_d.ny   = d_q.ny;
    e_d.divx = d_q.divx;
    e_d.divy = d_q.divy;
  end

  // stage F: size weight
  stf_t f_d, f_q;
  logic f_vld_q;

  always_comb begin
    f_d.fg   = e_q.fg;
    f_d.slot = e_q.slot;
    f_d.err  = e_q.err;
    f_d.sx   = e_q.sx;
    f_d.sy   = e_q.sy;
    f_d.sw   = e_q.sw;
    f_d.sh   = e_q.sh;
    f_d.mw   = 33'(e_q.lw) * 33'(size_weight_q);
    f_d.mh   = 33'(e_q.lh) * 33'(size_weight_q);
    f_d.nx   = e_q.nx;
    f_d.ny   = e_q.ny;
    f_d.divx = e_q.divx;
    f_d.divy = e_q.divy;
  end

  // stage G: ln2 partial products
  stg_t g_d, g_q;
  logic g_vld_q;

  always_comb begin
    g_d.fg   = f_q.fg;
    g_d.slot = f_q.slot;
    g_d.err  = f_q.err;
    g_d.sx   = f_q.sx;
    g_d.sy   = f_q.sy;
    g_d.sw   = f_q.sw;
    g_d.sh   = f_q.sh;
    g_d.hw   = 45'(f_q.mw) * 45'(bre_pkg::LN2_HI);
    g_d.lw   = 45'(f_q.mw) * 45'(bre_pkg::LN2_LO);
    g_d.hh   = 45'(f_q.mh) * 45'(bre_pkg::LN2_HI);
    g_d.lh   = 45'(f_q.mh) * 45'(bre_pkg::LN2_LO);
    g_d.nx   = f_q.nx;
    g_d.ny   = f_q.ny;
    g_d.divx = f_q.divx;
    g_d.divy = f_q.divy;
  end

  // stage H: sum, round, saturate size deltas; divider setup
  div_t        h_d, h_q;
  logic        h_vld_q;
  logic [57:0] fw_h, fh_h;

  assign fw_h = {1'b0, g_q.hw, 12'b0} + 58'(g_q.lw) + (58'd1 << 31);
  assign fh_h = {1'b0, g_q.hh, 12'b0} + 58'(g_q.lh) + (58'd1 << 31);

  always_comb begin
    h_d.fg   = g_q.fg;
    h_d.slot = g_q.slot;
    h_d.err  = g_q.err;
    h_d.sx   = g_q.sx;
    h_d.sy   = g_q.sy;
    h_d.dw   = sat_delta(g_q.sw, fw_h[57:32]);
    h_d.dh   = sat_delta(g_q.sh, fh_h[57:32]);
    h_d.rx   = 46'(g_q.nx);
    h_d.ry   = 46'(g_q.ny);
    h_d.divx = g_q.divx;
    h_d.divy = g_q.divy;
    h_d.qx   = '0;
    h_d.qy   = '0;
    h_d.ox   = 46'(g_q.nx) >= {g_q.divx, 24'b0};
    h_d.oy   = 46'(g_q.ny) >= {g_q.divy, 24'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    e_q <= e_d;
    f_q <= f_d;
    g_q <= g_d;
    h_q <= h_d;
  end

  // restoring divider, one quotient bit per stage
  div_t              dv_q   [DIV_BITS+1];
  logic [DIV_BITS:0] dv_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_vld_q <= '0;
    else         dv_vld_q <= {dv_vld_q[DIV_BITS-1:0], h_vld_q};
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= h_q;
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - k;
    div_t        s_d;
    logic [45:0] cx, cy;

    assign cx = {24'b0, dv_q[k-1].divx} << B;
    assign cy = {24'b0, dv_q[k-1].divy} << B;

    always_comb begin
      s_d = dv_q[k-1];
      if (dv_q[k-1].rx >= cx) begin
        s_d.rx    = dv_q[k-1].rx - cx;
        s_d.qx[B] = 1'b1;
      end
      if (dv_q[k-1].ry >= cy) begin
        s_d.ry    = dv_q[k-1].ry - cy;
        s_d.qy[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k] <= s_d;
    end
  end

  // output register
  div_t          last;
  bre_pkg::rsp_t rsp_d, rsp_q;
  logic          rsp_vld_q;

  assign last = dv_q[DIV_BITS];

  always_comb begin
    rsp_d.foreground = last.fg;
    rsp_d.class_slot = last.slot;
    rsp_d.error_code = last.err;
    if (last.fg) begin
      rsp_d.delta_x = sat_delta(last.sx, {1'b0, last.ox, last.qx});
      rsp_d.delta_y = sat_delta(last.sy, {1'b0, last.oy, last.qy});
      rsp_d.delta_w = last.dw;
      rsp_d.delta_h = last.dh;
    end else begin
      rsp_d.delta_x = '0;
      rsp_d.delta_y = '0;
      rsp_d.delta_w = '0;
      rsp_d.delta_h = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_vld_q <= 1'b0;
    else         rsp_vld_q <= dv_vld_q[DIV_BITS];
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign result_valid_o = rsp_vld_q;
  assign result_o       = rsp_q;

endmodule

@@ sv/bre_checker.sv @@
// ----------------------------------------------------------------------------
// bre_checker
// Port-level assertions of the box regression target encoder.
// ----------------------------------------------------------------------------
module bre_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          result_valid_o,
  input bre_pkg::rsp_t result_o
);

  // table fill runs once after reset
  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy raised after table fill");

  // foreground only on clean requests
  a_fg_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.foreground |->
      result_o.error_code == bre_pkg::ERR_OK && result_o.class_slot != '0)
    else $error("foreground result with error or background label");

  // background and error results carry zero deltas
  a_bg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.foreground |->
      result_o.delta_x == '0 && result_o.delta_y == '0 &&
      result_o.delta_w == '0 && result_o.delta_h == '0)
    else $error("nonzero delta on background result");

  // no result can come out while the table is still being filled
  a_no_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !result_valid_o)
    else $error("result during table fill");

  // unused error code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.error_code == bre_pkg::ERR_OK ||
      result_o.error_code == bre_pkg::ERR_GEOM ||
      result_o.error_code == bre_pkg::ERR_LABEL)
    else $error("undefined error code");

endmodule

bind box_regression_target_encoder_core bre_checker u_bre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
